// ===== rtl/three_axis_servo_slew_limiter_defines.svh =====
// Assertion macros for the three-axis servo slew limiter checker.
// Needs clk and rst_n in scope where a macro is used.
`ifndef THREE_AXIS_SERVO_SLEW_LIMITER_DEFINES_SVH
`define THREE_AXIS_SERVO_SLEW_LIMITER_DEFINES_SVH

// Clocked check, off while reset is held.
`define TASL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define TASL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tasl_pkg.sv =====
// Types and constants for the three-axis servo slew limiter.
// No dependencies.
package tasl_pkg;

  localparam int AXIS_COUNT  = 3;
  localparam int VALUE_WIDTH = 16;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [AXIS_COUNT-1:0]  axis_mask_t;

  localparam value_t RESET_POSITION = 16'd1875;

  typedef enum logic [1:0] {
    KIND_MOVE   = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_CANCEL = 2'd2
  } kind_t;

  localparam int AXIS_BASE  = 0;
  localparam int AXIS_LOWER = 1;
  localparam int AXIS_UPPER = 2;

  typedef struct packed {
    value_t pos;
    logic   done;
  } axis_res_t;

endpackage

// ===== rtl/three_axis_servo_slew_limiter.sv =====
// Three-axis servo slew limiter: input register, one-step update logic, result register.
// Uses tasl_pkg.
// An accepted item is held in the input register, then its update is held in the result register, where it is valid.
// Throughput: one item per cycle while out_ready is high; the input register takes an item while a result waits.
// The update of all axes is one add or subtract and compare per axis, all combinational.
// Reset (synchronous, rst_n low): positions 1875, goals and steps 0, axes done, no move.
module three_axis_servo_slew_limiter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  tasl_pkg::value_t    in_base_target,
  input  tasl_pkg::value_t    in_lower_target,
  input  tasl_pkg::value_t    in_upper_target,
  input  tasl_pkg::value_t    in_base_step,
  input  tasl_pkg::value_t    in_lower_step,
  input  tasl_pkg::value_t    in_upper_step,
  output logic                out_valid,
  input  logic                out_ready,
  output tasl_pkg::value_t    out_base_compare,
  output tasl_pkg::value_t    out_lower_compare,
  output tasl_pkg::value_t    out_upper_compare,
  output logic                out_moving,
  output logic                out_finished
);

  function automatic tasl_pkg::axis_res_t step_axis(
    input tasl_pkg::value_t pos,
    input tasl_pkg::value_t goal,
    input tasl_pkg::value_t rate,
    input logic             done
  );
    tasl_pkg::axis_res_t        res;
    logic [tasl_pkg::VALUE_WIDTH:0] up_sum;
    tasl_pkg::value_t           gap;
    up_sum   = {1'b0, pos} + {1'b0, rate};
    gap      = pos - goal;
    res.pos  = pos;
    res.done = done;
    if (!done) begin
      if (pos < goal) begin
        if (up_sum > {1'b0, goal}) begin
          res.pos  = goal;
          res.done = 1'b1;
        end else begin
          res.pos = up_sum[tasl_pkg::VALUE_WIDTH-1:0];
        end
      end else if (pos > goal) begin
        if (gap < rate) begin
          res.pos  = goal;
          res.done = 1'b1;
        end else begin
          res.pos = pos - rate;
        end
      end else begin
        res.done = 1'b1;
      end
    end
    return res;
  endfunction

  logic                 in_fire;
  logic                 s1_fire;
  logic                 s1_valid_r;
  logic [1:0]           s1_kind_r;
  tasl_pkg::value_t     s1_target_r [tasl_pkg::AXIS_COUNT];
  tasl_pkg::value_t     s1_step_r   [tasl_pkg::AXIS_COUNT];

  tasl_pkg::value_t     pos_r   [tasl_pkg::AXIS_COUNT];
  tasl_pkg::value_t     pos_nxt [tasl_pkg::AXIS_COUNT];
  tasl_pkg::value_t     goal_r  [tasl_pkg::AXIS_COUNT];
  tasl_pkg::value_t     goal_nxt[tasl_pkg::AXIS_COUNT];
  tasl_pkg::value_t     rate_r  [tasl_pkg::AXIS_COUNT];
  tasl_pkg::value_t     rate_nxt[tasl_pkg::AXIS_COUNT];
  tasl_pkg::axis_mask_t done_r;
  tasl_pkg::axis_mask_t done_nxt;
  logic                 active_r;
  logic                 active_nxt;
  logic                 finished_nxt;
  tasl_pkg::axis_res_t  res     [tasl_pkg::AXIS_COUNT];

  logic                 out_valid_r;
  tasl_pkg::value_t     out_pos_r [tasl_pkg::AXIS_COUNT];
  logic                 out_moving_r;
  logic                 out_finished_r;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r                         <= in_kind;
      s1_target_r[tasl_pkg::AXIS_BASE]  <= in_base_target;
      s1_target_r[tasl_pkg::AXIS_LOWER] <= in_lower_target;
      s1_target_r[tasl_pkg::AXIS_UPPER] <= in_upper_target;
      s1_step_r[tasl_pkg::AXIS_BASE]    <= in_base_step;
      s1_step_r[tasl_pkg::AXIS_LOWER]   <= in_lower_step;
      s1_step_r[tasl_pkg::AXIS_UPPER]   <= in_upper_step;
    end
  end

  always_comb begin
    pos_nxt      = pos_r;
    goal_nxt     = goal_r;
    rate_nxt     = rate_r;
    done_nxt     = done_r;
    active_nxt   = active_r;
    finished_nxt = 1'b0;
    for (int a = 0; a < tasl_pkg::AXIS_COUNT; a++) begin
      res[a] = step_axis(pos_r[a], goal_r[a], rate_r[a], done_r[a]);
    end
    case (s1_kind_r)
      tasl_pkg::KIND_MOVE: begin
        for (int a = 0; a < tasl_pkg::AXIS_COUNT; a++) begin
          res[a]      = step_axis(pos_r[a], s1_target_r[a], s1_step_r[a],
                                  (s1_step_r[a] == '0));
          goal_nxt[a] = s1_target_r[a];
          rate_nxt[a] = s1_step_r[a];
          pos_nxt[a]  = res[a].pos;
          done_nxt[a] = res[a].done;
        end
        active_nxt = 1'b1;
      end
      tasl_pkg::KIND_TICK: begin
        if (active_r) begin
          if (&done_r) begin
            active_nxt   = 1'b0;
            finished_nxt = 1'b1;
          end else begin
            for (int a = 0; a < tasl_pkg::AXIS_COUNT; a++) begin
              pos_nxt[a]  = res[a].pos;
              done_nxt[a] = res[a].done;
            end
          end
        end
      end
      tasl_pkg::KIND_CANCEL: begin
        active_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < tasl_pkg::AXIS_COUNT; a++) begin
        pos_r[a]  <= tasl_pkg::RESET_POSITION;
        goal_r[a] <= '0;
        rate_r[a] <= '0;
      end
      done_r   <= '1;
      active_r <= 1'b0;
    end else if (s1_fire) begin
      pos_r    <= pos_nxt;
      goal_r   <= goal_nxt;
      rate_r   <= rate_nxt;
      done_r   <= done_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pos_r      <= pos_nxt;
      out_moving_r   <= active_nxt;
      out_finished_r <= finished_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_base_compare  = out_pos_r[tasl_pkg::AXIS_BASE];
  assign out_lower_compare = out_pos_r[tasl_pkg::AXIS_LOWER];
  assign out_upper_compare = out_pos_r[tasl_pkg::AXIS_UPPER];
  assign out_moving        = out_moving_r;
  assign out_finished      = out_finished_r;

endmodule

// ===== rtl/tasl_checker.sv =====
// Port-level checks for the three-axis servo slew limiter, bound to the top level.
// Uses the macros in three_axis_servo_slew_limiter_defines.svh.
`include "three_axis_servo_slew_limiter_defines.svh"

module tasl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_base_compare,
  input logic        out_moving,
  input logic        out_finished
);

  `TASL_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `TASL_ASSERT(a_out_holds, out_valid && !out_ready |=> out_valid && $stable(out_base_compare), "stalled result dropped or changed")
  `TASL_ASSERT(a_finish_stops, out_valid && out_finished |-> !out_moving, "finished item still moving")
  `TASL_ASSERT(a_finish_once, out_valid && out_ready && out_finished ##1 out_valid |-> !out_finished, "two finishes in a row")

endmodule

bind three_axis_servo_slew_limiter tasl_checker u_tasl_checker (.*);
